// ===== hw/rtl/irpdt_pkg.sv =====
`default_nettype none

package irpdt_pkg;

   // Frame and field widths.
   localparam int unsigned MaxBits     = 32;
   localparam int unsigned WordW       = 32;
   localparam int unsigned CountW      = 6;
   localparam int unsigned ShiftW      = 5;
   localparam int unsigned TpuW        = 8;
   localparam int unsigned CarrierW    = 16;
   localparam int unsigned DurW        = 13;
   localparam int unsigned CsrIndexW   = 3;
   localparam int unsigned CsrDataW    = 16;

   // Input operation codes.
   localparam logic OpTick  = 1'b0;
   localparam logic OpStart = 1'b1;

   // Frame phases.
   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_HDR_MARK  = 3'd1,
      PH_HDR_SPACE = 3'd2,
      PH_BIT_MARK  = 3'd3,
      PH_BIT_SPACE = 3'd4,
      PH_FOOTER    = 3'd5
   } phase_type;

   // Configuration register indexes.
   typedef enum logic [CsrIndexW-1:0] {
      CSR_TICKS_PER_US    = 3'd0,
      CSR_CARRIER_PERIOD  = 3'd1,
      CSR_CARRIER_HIGH    = 3'd2,
      CSR_HEADER_MARK_US  = 3'd3,
      CSR_HEADER_SPACE_US = 3'd4,
      CSR_BIT_MARK_US     = 3'd5,
      CSR_ONE_SPACE_US    = 3'd6,
      CSR_ZERO_SPACE_US   = 3'd7
   } csr_index_type;

   // Configuration reset values.
   localparam logic [TpuW-1:0]     RstTicksPerUs    = 8'd16;
   localparam logic [CarrierW-1:0] RstCarrierPeriod = 16'd420;
   localparam logic [CarrierW-1:0] RstCarrierHigh   = 16'd140;
   localparam logic [DurW-1:0]     RstHeaderMarkUs  = 13'd5000;
   localparam logic [DurW-1:0]     RstHeaderSpaceUs = 13'd5000;
   localparam logic [DurW-1:0]     RstBitMarkUs     = 13'd560;
   localparam logic [DurW-1:0]     RstOneSpaceUs    = 13'd1600;
   localparam logic [DurW-1:0]     RstZeroSpaceUs   = 13'd560;

   // A duration of zero microseconds counts as one.
   function automatic logic [DurW-1:0] dur_fix(input logic [DurW-1:0] us);
      dur_fix = (us == '0) ? DurW'(1) : us;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/irpdt_if.sv =====
`default_nettype none

// Request channel: tick or start items.
interface irpdt_req_if;
   logic                                valid;
   logic                                ready;
   logic                                op;
   logic [irpdt_pkg::WordW-1:0]         payload;
   logic [irpdt_pkg::CountW-1:0]        bit_count;

   modport source (output valid, output op, output payload, output bit_count, input ready);
   modport sink   (input valid, input op, input payload, input bit_count, output ready);
endinterface

// Response channel: line status after each item.
interface irpdt_rsp_if;
   logic valid;
   logic ready;
   logic led_on;
   logic envelope;
   logic busy_res;
   logic done_res;
   logic rejected;

   modport source (output valid, output led_on, output envelope, output busy_res,
                   output done_res, output rejected, input ready);
   modport sink   (input valid, input led_on, input envelope, input busy_res,
                   input done_res, input rejected, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ir_pulse_distance_transmitter.sv =====
// Response: the response to an item is registered and presented in the cycle after the item is accepted.
// Throughput: one item per cycle; the frame state and the response register are
// updated together, and a new item is taken whenever the response register is
// empty or being drained in the same cycle.
// Reset: synchronous, active high; restores the default timing registers and an idle line.
`default_nettype none

module ir_pulse_distance_transmitter (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   irpdt_req_if.sink                                 req_bus,
   irpdt_rsp_if.source                               rsp_bus,
   input  wire logic                                 csr_we,
   input  wire logic [irpdt_pkg::CsrIndexW-1:0]      csr_index,
   input  wire logic [irpdt_pkg::CsrDataW-1:0]       csr_wdata
);

   localparam int unsigned WordW    = irpdt_pkg::WordW;
   localparam int unsigned CountW   = irpdt_pkg::CountW;
   localparam int unsigned ShiftW   = irpdt_pkg::ShiftW;
   localparam int unsigned TpuW     = irpdt_pkg::TpuW;
   localparam int unsigned CarrierW = irpdt_pkg::CarrierW;
   localparam int unsigned DurW     = irpdt_pkg::DurW;

   // Configuration registers.
   logic [TpuW-1:0]     ticks_per_us_ff;
   logic [CarrierW-1:0] carrier_period_ff;
   logic [CarrierW-1:0] carrier_high_ff;
   logic [DurW-1:0]     header_mark_us_ff;
   logic [DurW-1:0]     header_space_us_ff;
   logic [DurW-1:0]     bit_mark_us_ff;
   logic [DurW-1:0]     one_space_us_ff;
   logic [DurW-1:0]     zero_space_us_ff;

   // Frame state.
   irpdt_pkg::phase_type phase_ff, phase_in;
   logic [WordW-1:0]    shift_word_ff, shift_word_in;
   logic [CountW-1:0]   bits_left_ff, bits_left_in;
   logic [TpuW-1:0]     us_prescale_ff, us_prescale_in;
   logic [DurW-1:0]     us_remaining_ff, us_remaining_in;
   logic [CarrierW-1:0] carrier_count_ff, carrier_count_in;
   logic                done_in, rejected_in;

   // Response register.
   logic rsp_valid_ff;
   logic led_on_ff, envelope_ff, busy_ff, done_ff, rejected_ff;
   logic led_on_in, envelope_in, busy_in;

   logic req_fire;

   // Take an item when the response register is free or draining.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_us_ff    <= irpdt_pkg::RstTicksPerUs;
         carrier_period_ff  <= irpdt_pkg::RstCarrierPeriod;
         carrier_high_ff    <= irpdt_pkg::RstCarrierHigh;
         header_mark_us_ff  <= irpdt_pkg::RstHeaderMarkUs;
         header_space_us_ff <= irpdt_pkg::RstHeaderSpaceUs;
         bit_mark_us_ff     <= irpdt_pkg::RstBitMarkUs;
         one_space_us_ff    <= irpdt_pkg::RstOneSpaceUs;
         zero_space_us_ff   <= irpdt_pkg::RstZeroSpaceUs;
      end else if (csr_we) begin
         unique case (irpdt_pkg::csr_index_type'(csr_index))
            irpdt_pkg::CSR_TICKS_PER_US:    ticks_per_us_ff    <= csr_wdata[TpuW-1:0];
            irpdt_pkg::CSR_CARRIER_PERIOD:  carrier_period_ff  <= csr_wdata[CarrierW-1:0];
            irpdt_pkg::CSR_CARRIER_HIGH:    carrier_high_ff    <= csr_wdata[CarrierW-1:0];
            irpdt_pkg::CSR_HEADER_MARK_US:  header_mark_us_ff  <= csr_wdata[DurW-1:0];
            irpdt_pkg::CSR_HEADER_SPACE_US: header_space_us_ff <= csr_wdata[DurW-1:0];
            irpdt_pkg::CSR_BIT_MARK_US:     bit_mark_us_ff     <= csr_wdata[DurW-1:0];
            irpdt_pkg::CSR_ONE_SPACE_US:    one_space_us_ff    <= csr_wdata[DurW-1:0];
            irpdt_pkg::CSR_ZERO_SPACE_US:   zero_space_us_ff   <= csr_wdata[DurW-1:0];
            default: ;
         endcase
      end
   end

   // Next frame state for the item at the input.
   always_comb begin
      logic [CountW-1:0]   count;
      logic [ShiftW-1:0]   shamt;
      logic [TpuW-1:0]     tpu;
      logic [CarrierW:0]   cc_sum;
      logic [TpuW:0]       pre_sum;
      logic [DurW-1:0]     rem_dec;
      logic [CountW-1:0]   bits_dec;

      phase_in         = phase_ff;
      shift_word_in    = shift_word_ff;
      bits_left_in     = bits_left_ff;
      us_prescale_in   = us_prescale_ff;
      us_remaining_in  = us_remaining_ff;
      carrier_count_in = carrier_count_ff;
      done_in          = 1'b0;
      rejected_in      = 1'b0;

      // Clamp the bit count into one to the frame maximum.
      count = req_bus.bit_count;
      if (count == '0) begin
         count = CountW'(1);
      end else if (count > CountW'(irpdt_pkg::MaxBits)) begin
         count = CountW'(irpdt_pkg::MaxBits);
      end
      shamt = ShiftW'(CountW'(irpdt_pkg::MaxBits) - count);

      tpu      = (ticks_per_us_ff == '0) ? TpuW'(1) : ticks_per_us_ff;
      cc_sum   = {1'b0, carrier_count_ff} + (CarrierW+1)'(1);
      pre_sum  = {1'b0, us_prescale_ff} + (TpuW+1)'(1);
      rem_dec  = us_remaining_ff - DurW'(1);
      bits_dec = bits_left_ff - CountW'(1);

      if (req_bus.op == irpdt_pkg::OpStart) begin
         // A start only loads a frame when the line is idle.
         if (phase_ff != irpdt_pkg::PH_IDLE) begin
            rejected_in = 1'b1;
         end else begin
            shift_word_in   = req_bus.payload << shamt;
            bits_left_in    = count;
            phase_in        = irpdt_pkg::PH_HDR_MARK;
            us_remaining_in = irpdt_pkg::dur_fix(header_mark_us_ff);
            us_prescale_in  = '0;
         end
      end else begin
         // The carrier counter runs on every tick.
         if (cc_sum >= {1'b0, carrier_period_ff}) begin
            carrier_count_in = '0;
         end else begin
            carrier_count_in = cc_sum[CarrierW-1:0];
         end

         // Frame timing advances one microsecond every tpu ticks.
         if (phase_ff != irpdt_pkg::PH_IDLE) begin
            if (pre_sum >= {1'b0, tpu}) begin
               us_prescale_in  = '0;
               us_remaining_in = rem_dec;
               if (rem_dec == '0) begin
                  unique case (phase_ff)
                     irpdt_pkg::PH_HDR_MARK: begin
                        phase_in        = irpdt_pkg::PH_HDR_SPACE;
                        us_remaining_in = irpdt_pkg::dur_fix(header_space_us_ff);
                     end
                     irpdt_pkg::PH_HDR_SPACE: begin
                        phase_in        = irpdt_pkg::PH_BIT_MARK;
                        us_remaining_in = irpdt_pkg::dur_fix(bit_mark_us_ff);
                     end
                     irpdt_pkg::PH_BIT_MARK: begin
                        phase_in        = irpdt_pkg::PH_BIT_SPACE;
                        us_remaining_in = irpdt_pkg::dur_fix(shift_word_ff[WordW-1] ?
                                                             one_space_us_ff :
                                                             zero_space_us_ff);
                     end
                     irpdt_pkg::PH_BIT_SPACE: begin
                        shift_word_in   = shift_word_ff << 1;
                        bits_left_in    = bits_dec;
                        phase_in        = (bits_dec == '0) ? irpdt_pkg::PH_FOOTER :
                                                             irpdt_pkg::PH_BIT_MARK;
                        us_remaining_in = irpdt_pkg::dur_fix(bit_mark_us_ff);
                     end
                     default: begin
                        // Footer mark done: the frame ends.
                        phase_in        = irpdt_pkg::PH_IDLE;
                        us_remaining_in = '0;
                        done_in         = 1'b1;
                     end
                  endcase
               end
            end else begin
               us_prescale_in = pre_sum[TpuW-1:0];
            end
         end
      end
   end

   // Line outputs from the state after the item.
   always_comb begin
      envelope_in = (phase_in == irpdt_pkg::PH_HDR_MARK) ||
                    (phase_in == irpdt_pkg::PH_BIT_MARK) ||
                    (phase_in == irpdt_pkg::PH_FOOTER);
      led_on_in   = envelope_in && (carrier_count_in < carrier_high_ff);
      busy_in     = (phase_in != irpdt_pkg::PH_IDLE);
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= irpdt_pkg::PH_IDLE;
         shift_word_ff    <= '0;
         bits_left_ff     <= '0;
         us_prescale_ff   <= '0;
         us_remaining_ff  <= '0;
         carrier_count_ff <= '0;
      end else if (req_fire) begin
         phase_ff         <= phase_in;
         shift_word_ff    <= shift_word_in;
         bits_left_ff     <= bits_left_in;
         us_prescale_ff   <= us_prescale_in;
         us_remaining_ff  <= us_remaining_in;
         carrier_count_ff <= carrier_count_in;
      end
   end

   // Response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         led_on_ff   <= led_on_in;
         envelope_ff <= envelope_in;
         busy_ff     <= busy_in;
         done_ff     <= done_in;
         rejected_ff <= rejected_in;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.led_on   = led_on_ff;
   assign rsp_bus.envelope = envelope_ff;
   assign rsp_bus.busy_res = busy_ff;
   assign rsp_bus.done_res = done_ff;
   assign rsp_bus.rejected = rejected_ff;

endmodule

`default_nettype wire
